// File: hdl/swpr_pkg.sv
// shared types and constants of the stop-and-wait packet receiver
package swpr_pkg;

  localparam int unsigned MAGIC_RUN_LENGTH = 4;
  localparam int unsigned LEN_W            = 21;
  localparam int unsigned SEQ_W            = 32;
  localparam int unsigned SUM_W            = 16;
  localparam int unsigned PADDR_W          = 3;
  localparam int unsigned PDATA_W          = 32;

  localparam logic [7:0]       MAGIC_BYTE   = 8'hAA;
  localparam logic [SUM_W-1:0] SUM_GOOD     = 16'hFFFF;
  localparam logic [SEQ_W-1:0] EXP_SEQ_RST  = 32'd1;
  localparam logic [SEQ_W-1:0] EXP_SEQ_EOT  = 32'hFFFF_FFFF;
  localparam logic [LEN_W-1:0] MAX_LEN_RST  = 21'd20000;

  typedef enum logic {
    OP_BYTE    = 1'b0,
    OP_TIMEOUT = 1'b1
  } swpr_op_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_ACK     = 1'b1
  } swpr_kind_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EOT     = 3'd1,
    ST_BADSUM  = 3'd2,
    ST_BADSEQ  = 3'd3,
    ST_TOOLONG = 3'd4,
    ST_TIMEOUT = 3'd5
  } swpr_status_e;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_SEQ     = 3'd1,
    PH_LEN     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CSUM    = 3'd4
  } swpr_phase_e;

  typedef enum logic [PADDR_W-3:0] {
    REG_MAX_LENGTH = 1'b0
  } swpr_reg_e;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } swpr_item_t;

  typedef struct packed {
    logic             emit;
    logic             kind;
    logic [7:0]       payload_byte;
    logic [SEQ_W-1:0] ack_value;
    logic [2:0]       status;
  } swpr_result_t;

endpackage

// File: hdl/swpr_if.sv
// word channels: received bytes in, payload bytes and acknowledges out
interface swpr_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface swpr_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [31:0] ack_value;
  logic [2:0]  status;

  modport source (output valid, output kind, output payload_byte, output ack_value,
                  output status, input ready);
  modport sink   (input valid, input kind, input payload_byte, input ack_value,
                  input status, output ready);
endinterface

// File: hdl/stop_and_wait_packet_receiver.sv
// top level of the stop-and-wait packet receiver
//
// din_i carries one word per received byte (opcode 0) or per receive
// timeout (opcode 1). The block hunts for a run of 0xAA bytes, then parses
// a little-endian sequence number, length, payload and 16-bit checksum.
// dout_o carries one word per payload byte (kind 0) as it arrives, and one
// acknowledge (kind 1) with sequence and status at the end of each packet.
// Items that finish no result give no dout_o word.
// An accepted word waits in the input register until the core consumes it;
// its result, if any, is then registered in the output register for dout_o.
// Throughput is one word per cycle while dout_o is not stalled; the parser
// state machine updates once per consumed word.
// When dout_o stalls, the output register holds its word and the input
// register takes one more word, after which din_i.ready drops.
// The apb port holds max_length at address 0; write it only while idle.
// Reset clears the parser to hunting, the expected sequence to one and
// max_length to 20000.
module stop_and_wait_packet_receiver import swpr_pkg::*; #(
  parameter int unsigned MagicRunLength = MAGIC_RUN_LENGTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  swpr_in_if.sink            din_i,
  swpr_out_if.source         dout_o
);

  logic             in_vld_q, in_vld_d;
  swpr_item_t       in_item_q;
  logic             out_vld_q, out_vld_d;
  swpr_result_t     out_res_q;
  swpr_result_t     res;
  logic             out_free;
  logic             step;
  logic             in_take;
  logic [LEN_W-1:0] max_length;

  swpr_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .max_length_o (max_length)
  );

  swpr_core #(
    .MagicRunLength (MagicRunLength)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .item_i       (in_item_q),
    .max_length_i (max_length),
    .res_o        (res)
  );

  assign out_free    = !out_vld_q || dout_o.ready;
  assign step        = in_vld_q && out_free;
  assign din_i.ready = !in_vld_q || out_free;
  assign in_take     = din_i.valid && din_i.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (step) begin
      out_vld_d = res.emit;
    end else if (dout_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.opcode  <= din_i.opcode;
      in_item_q.rx_byte <= din_i.rx_byte;
    end
    if (step) begin
      out_res_q <= res;
    end
  end

  assign dout_o.valid        = out_vld_q;
  assign dout_o.kind         = out_res_q.kind;
  assign dout_o.payload_byte = out_res_q.payload_byte;
  assign dout_o.ack_value    = out_res_q.ack_value;
  assign dout_o.status       = out_res_q.status;

`ifndef SYNTHESIS
  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !step |=> in_vld_q)
    else $error("input word dropped while stalled");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && out_vld_q && !dout_o.ready |-> !din_i.ready)
    else $error("input taken while both stages are full");

  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_res_q.kind == KIND_PAYLOAD |->
      out_res_q.ack_value == '0 && out_res_q.status == ST_OK)
    else $error("payload word carries acknowledge fields");

  a_ack_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_res_q.kind == KIND_ACK |-> out_res_q.payload_byte == '0)
    else $error("acknowledge carries a payload byte");
`endif

endmodule

// File: hdl/swpr_cfg.sv
// apb register block holding the maximum packet length
module swpr_cfg import swpr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [LEN_W-1:0]   max_length_o
);

  logic [LEN_W-1:0] max_len_q, max_len_d;
  logic             wr_en;
  logic             sel_max;

  assign pready  = 1'b1;
  assign sel_max = (paddr[PADDR_W-1:2] == REG_MAX_LENGTH);
  assign wr_en   = psel && penable && pwrite && pready && sel_max;

  always_comb begin
    max_len_d = max_len_q;
    if (wr_en) begin
      max_len_d = pwdata[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RST;
    end else begin
      max_len_q <= max_len_d;
    end
  end

  assign prdata       = sel_max ? PDATA_W'(max_len_q) : '0;
  assign max_length_o = max_len_q;

endmodule

// File: hdl/swpr_core.sv
// packet parser, checksum and sequence state machine
module swpr_core import swpr_pkg::*; #(
  parameter int unsigned MagicRunLength = MAGIC_RUN_LENGTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  swpr_item_t         item_i,
  input  logic [LEN_W-1:0]   max_length_i,
  output swpr_result_t       res_o
);

  localparam int unsigned RunW = $clog2(MagicRunLength + 1);

  swpr_phase_e       phase_q, phase_d;
  logic [RunW-1:0]   run_q, run_d;
  logic [SEQ_W-1:0]  exp_seq_q, exp_seq_d;
  logic              any_q, any_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic [SEQ_W-1:0]  seq_q, seq_d;
  logic [SEQ_W-1:0]  len_q, len_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [7:0]        held_q, held_d;

  logic [7:0]        b;
  logic [RunW-1:0]   run_inc;
  logic [LEN_W-1:0]  cnt_inc;
  logic [SEQ_W-1:0]  seq_full;
  logic [SEQ_W-1:0]  len_full;
  logic [SUM_W:0]    sum_raw;
  logic [SUM_W-1:0]  sum_oc;
  logic              do_ack;
  logic [SEQ_W-1:0]  ack_val;
  swpr_status_e      ack_st;

  assign b        = item_i.rx_byte;
  assign run_inc  = run_q + 1'b1;
  assign cnt_inc  = cnt_q + 1'b1;
  assign seq_full = {b, seq_q[SEQ_W-1:8]};
  assign len_full = {b, len_q[SEQ_W-1:8]};
  assign sum_raw  = {1'b0, sum_q} + {1'b0, b, held_q};
  assign sum_oc   = sum_raw[SUM_W-1:0] + SUM_W'(sum_raw[SUM_W]);

  always_comb begin
    phase_d   = phase_q;
    run_d     = run_q;
    exp_seq_d = exp_seq_q;
    any_d     = any_q;
    cnt_d     = cnt_q;
    seq_d     = seq_q;
    len_d     = len_q;
    sum_d     = sum_q;
    held_d    = held_q;
    do_ack    = 1'b0;
    ack_val   = exp_seq_q - 1'b1;
    ack_st    = ST_OK;
    res_o     = '0;

    if (item_i.opcode == OP_TIMEOUT) begin
      if (phase_q != PH_HUNT) begin
        do_ack = 1'b1;
        ack_st = ST_TIMEOUT;
      end
    end else begin
      case (phase_q)
        PH_HUNT: begin
          if (b == MAGIC_BYTE) begin
            if (run_inc >= RunW'(MagicRunLength)) begin
              run_d   = '0;
              cnt_d   = '0;
              seq_d   = '0;
              phase_d = PH_SEQ;
            end else begin
              run_d = run_inc;
            end
          end else begin
            run_d = '0;
          end
        end
        PH_SEQ: begin
          seq_d = seq_full;
          cnt_d = cnt_inc;
          if (cnt_q[1:0] == 2'd3) begin
            cnt_d   = '0;
            len_d   = '0;
            phase_d = PH_LEN;
          end
        end
        PH_LEN: begin
          len_d = len_full;
          cnt_d = cnt_inc;
          if (cnt_q[1:0] == 2'd3) begin
            cnt_d  = '0;
            sum_d  = '0;
            held_d = '0;
            if (!any_q && seq_q == exp_seq_q && len_full == '0) begin
              do_ack    = 1'b1;
              ack_val   = seq_q;
              ack_st    = ST_EOT;
              any_d     = 1'b1;
              exp_seq_d = EXP_SEQ_EOT;
            end else if (len_full >= SEQ_W'(max_length_i)) begin
              do_ack = 1'b1;
              ack_st = ST_TOOLONG;
            end else if (len_full == '0) begin
              phase_d = PH_CSUM;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          if (!cnt_q[0]) begin
            held_d = b;
          end else begin
            sum_d = sum_oc;
          end
          cnt_d = cnt_inc;
          if (cnt_inc >= len_q[LEN_W-1:0]) begin
            cnt_d   = '0;
            phase_d = PH_CSUM;
          end
          res_o.emit         = 1'b1;
          res_o.kind         = KIND_PAYLOAD;
          res_o.payload_byte = b;
        end
        PH_CSUM: begin
          if (cnt_q == '0) begin
            held_d = b;
            cnt_d  = LEN_W'(1);
          end else if (sum_oc != SUM_GOOD) begin
            do_ack = 1'b1;
            ack_st = ST_BADSUM;
          end else if (!any_q && seq_q != exp_seq_q) begin
            do_ack = 1'b1;
            ack_st = ST_BADSEQ;
          end else begin
            do_ack    = 1'b1;
            ack_val   = seq_q;
            ack_st    = ST_OK;
            any_d     = 1'b0;
            exp_seq_d = seq_q + 1'b1;
          end
        end
        default: begin
          phase_d = PH_HUNT;
          run_d   = '0;
          cnt_d   = '0;
        end
      endcase
    end

    if (do_ack) begin
      phase_d         = PH_HUNT;
      run_d           = '0;
      cnt_d           = '0;
      res_o.emit      = 1'b1;
      res_o.kind      = KIND_ACK;
      res_o.ack_value = ack_val;
      res_o.status    = ack_st;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      run_q     <= '0;
      exp_seq_q <= EXP_SEQ_RST;
      any_q     <= 1'b0;
      cnt_q     <= '0;
      seq_q     <= '0;
      len_q     <= '0;
      sum_q     <= '0;
      held_q    <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      run_q     <= run_d;
      exp_seq_q <= exp_seq_d;
      any_q     <= any_d;
      cnt_q     <= cnt_d;
      seq_q     <= seq_d;
      len_q     <= len_d;
      sum_q     <= sum_d;
      held_q    <= held_d;
    end
  end

endmodule

// File: sim/stop_and_wait_packet_receiver_tb.sv
// testbench of the stop-and-wait packet receiver: framed byte streams in, payload and acks checked
module stop_and_wait_packet_receiver_tb import swpr_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASE_WORDS  = 230;

  typedef bit [7:0] octet_q_t[$];

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [31:0] ack_value;
    logic [2:0]  status;
  } tx_word_t;

  class swpr_scoreboard;
    swpr_phase_e  phase;
    int unsigned  magic_run;
    bit [31:0]    exp_seq;
    bit           accept_any;
    bit [31:0]    count;
    bit [31:0]    seq_field;
    bit [31:0]    len_field;
    bit [15:0]    csum;
    bit [7:0]     low_byte;
    bit [LEN_W-1:0] max_len;
    int unsigned  errors;
    tx_word_t     expected_out[$];

    function new();
      phase      = PH_HUNT;
      magic_run  = 0;
      exp_seq    = EXP_SEQ_RST;
      accept_any = 1'b0;
      count      = '0;
      seq_field  = '0;
      len_field  = '0;
      csum       = '0;
      low_byte   = '0;
      max_len    = MAX_LEN_RST;
      errors     = 0;
    endfunction

    function bit [15:0] ones_add(bit [15:0] a, bit [15:0] b);
      bit [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s > 17'h0FFFF) s = s - 17'h0FFFF;
      return s[15:0];
    endfunction

    function void push_ack(bit [31:0] value, swpr_status_e st);
      expected_out.push_back('{KIND_ACK, 8'd0, value, st});
      phase     = PH_HUNT;
      magic_run = 0;
      count     = '0;
    endfunction

    function void push_error(swpr_status_e st);
      push_ack(exp_seq - 32'd1, st);
    endfunction

    function void note_rx_word(swpr_op_e op, bit [7:0] b);
      if (op == OP_TIMEOUT) begin
        if (phase != PH_HUNT) push_error(ST_TIMEOUT);
        return;
      end
      case (phase)
        PH_HUNT: begin
          if (b == MAGIC_BYTE) begin
            magic_run++;
            if (magic_run >= MAGIC_RUN_LENGTH) begin
              magic_run = 0;
              count     = '0;
              seq_field = '0;
              phase     = PH_SEQ;
            end
          end else begin
            magic_run = 0;
          end
        end
        PH_SEQ: begin
          seq_field[8*count[1:0] +: 8] = b;
          count++;
          if (count >= 4) begin
            count     = '0;
            len_field = '0;
            phase     = PH_LEN;
          end
        end
        PH_LEN: begin
          len_field[8*count[1:0] +: 8] = b;
          count++;
          if (count >= 4) begin
            count    = '0;
            csum     = '0;
            low_byte = '0;
            if (!accept_any && seq_field == exp_seq && len_field == 0) begin
              accept_any = 1'b1;
              push_ack(seq_field, ST_EOT);
              exp_seq = EXP_SEQ_EOT;
            end else if (len_field >= 32'(max_len)) begin
              push_error(ST_TOOLONG);
            end else begin
              phase = (len_field == 0) ? PH_CSUM : PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          if (!count[0]) low_byte = b;
          else csum = ones_add(csum, {b, low_byte});
          count++;
          if (count >= len_field) begin
            count = '0;
            phase = PH_CSUM;
          end
          expected_out.push_back('{KIND_PAYLOAD, b, 32'd0, ST_OK});
        end
        PH_CSUM: begin
          if (count == 0) begin
            low_byte = b;
            count    = 32'd1;
          end else if (ones_add(csum, {b, low_byte}) != SUM_GOOD) begin
            push_error(ST_BADSUM);
          end else if (!accept_any && seq_field != exp_seq) begin
            push_error(ST_BADSEQ);
          end else begin
            accept_any = 1'b0;
            exp_seq    = seq_field + 32'd1;
            push_ack(seq_field, ST_OK);
          end
        end
        default: begin
          phase     = PH_HUNT;
          magic_run = 0;
          count     = '0;
        end
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_tx_word(tx_word_t got);
      tx_word_t want;
      if (expected_out.size() == 0) begin
        $display("%0t: unexpected word, expected none actual kind %0h byte %0h ack %0h status %0h",
                 $time, got.kind, got.payload_byte, got.ack_value, got.status);
        errors++;
        return;
      end
      want = expected_out.pop_front();
      compare_field("kind", 32'(want.kind), 32'(got.kind));
      compare_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
      compare_field("ack_value", want.ack_value, got.ack_value);
      compare_field("status", 32'(want.status), 32'(got.status));
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  swpr_in_if  din ();
  swpr_out_if dout ();

  swpr_scoreboard sb = new();

  int unsigned words_sent = 0;
  int unsigned burst_left = 0;

  int unsigned rx_cycle = 0;
  int unsigned rx_hold  = 0;
  bit          rx_level = 1'b1;
  bit [1:0]    rx_mode  = 2'd0;

  stop_and_wait_packet_receiver i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .din_i   (din),
    .dout_o  (dout)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rx_cycle % 300 == 0) rx_mode = 2'($urandom_range(0, 3));
    rx_cycle++;
    case (rx_mode)
      2'd0: dout.ready <= 1'b1;
      2'd1: dout.ready <= 1'($urandom_range(0, 1));
      2'd2: dout.ready <= (rx_cycle % 4 == 0);
      default: begin
        if (rx_hold == 0) begin
          rx_level = !rx_level;
          rx_hold  = $urandom_range(1, 24);
        end
        rx_hold--;
        dout.ready <= rx_level;
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (dout.valid === 1'b1 && dout.ready === 1'b1) begin
      sb.check_tx_word('{dout.kind, dout.payload_byte, dout.ack_value, dout.status});
    end
  end

  task automatic send_word(swpr_op_e op, bit [7:0] b);
    if (burst_left == 0) begin
      din.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 20);
    end
    burst_left--;
    din.valid   <= 1'b1;
    din.opcode  <= op;
    din.rx_byte <= b;
    do @(posedge clk_i); while (din.ready !== 1'b1);
    if (!(op == OP_TIMEOUT && sb.phase == PH_HUNT)) words_sent++;
    sb.note_rx_word(op, b);
  endtask

  task automatic drain();
    din.valid <= 1'b0;
    burst_left = 0;
    while (sb.expected_out.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_max_length(bit [LEN_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_MAX_LENGTH, 2'b00};
    pwdata  <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    sb.max_len = value;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata !== PDATA_W'(value)) begin
      $display("%0t: max_length readback mismatch, expected %0h actual %0h",
               $time, value, prdata);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_frame(bit [31:0] seq, bit [31:0] len, octet_q_t body, bit corrupt,
                            int cut);
    octet_q_t  frame;
    bit [15:0] sum;
    sum = '0;
    repeat (MAGIC_RUN_LENGTH) frame.push_back(MAGIC_BYTE);
    for (int i = 0; i < 4; i++) frame.push_back(seq[8*i +: 8]);
    for (int i = 0; i < 4; i++) frame.push_back(len[8*i +: 8]);
    foreach (body[i]) frame.push_back(body[i]);
    for (int i = 0; i + 1 < body.size(); i += 2) sum = sb.ones_add(sum, {body[i+1], body[i]});
    sum = ~sum;
    if (corrupt) sum = sum ^ (16'd1 << $urandom_range(0, 15));
    frame.push_back(sum[7:0]);
    frame.push_back(sum[15:8]);
    if (cut >= 0) begin
      for (int i = 0; i < cut; i++) send_word(OP_BYTE, frame[i]);
      send_word(OP_TIMEOUT, 8'($urandom));
    end else begin
      foreach (frame[i]) send_word(OP_BYTE, frame[i]);
    end
  endtask

  task automatic random_packet();
    int unsigned pick;
    bit [31:0]   seq;
    bit [31:0]   len;
    bit [31:0]   lim;
    bit          corrupt;
    bit          too_long;
    int          cut;
    octet_q_t    body;
    pick     = $urandom_range(0, 99);
    corrupt  = 1'b0;
    too_long = 1'b0;
    cut      = -1;
    lim      = 32'(sb.max_len) - 32'd1;
    if ($urandom_range(0, 19) == 0) begin
      send_word(OP_BYTE, MAGIC_BYTE);
      send_word(OP_BYTE, MAGIC_BYTE);
      send_word(OP_BYTE, 8'($urandom_range(0, 8'hA9)));
    end
    if (sb.magic_run != 0) send_word(OP_BYTE, 8'($urandom_range(0, 8'hA9)));
    if ($urandom_range(0, 9) == 0) send_word(OP_TIMEOUT, 8'($urandom));
    seq = (sb.accept_any || $urandom_range(0, 9) == 0) ? $urandom : sb.exp_seq;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
    if (pick < 50) begin
    end else if (pick < 58) begin
      len = '0;
      seq = sb.exp_seq;
    end else if (pick < 64) begin
      len = '0;
      seq = $urandom;
    end else if (pick < 72) begin
      corrupt = 1'b1;
    end else if (pick < 80) begin
      seq = sb.exp_seq + ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'($urandom_range(1, 3)));
    end else if (pick < 88) begin
      too_long = 1'b1;
      case ($urandom_range(0, 2))
        0:       len = 32'(sb.max_len);
        1:       len = 32'(sb.max_len) + 32'($urandom_range(1, 5));
        default: len = $urandom | 32'h0020_0000;
      endcase
    end else begin
      if (lim > 16 && $urandom_range(0, 1)) len = lim;
      cut = 0;
    end
    if (!too_long) begin
      if (len > lim) len = lim;
      for (int i = 0; i < len && i < 48; i++) body.push_back(8'($urandom));
    end
    if (cut == 0) cut = $urandom_range(MAGIC_RUN_LENGTH, MAGIC_RUN_LENGTH + 9 + body.size());
    send_frame(seq, len, body, corrupt, cut);
    if ($urandom_range(0, 49) == 0) drain();
  endtask

  initial begin
    octet_q_t    opening;
    bit [31:0]   target;
    bit [LEN_W-1:0] setting;
    din.valid   = 1'b0;
    din.opcode  = OP_BYTE;
    din.rx_byte = 8'd0;
    dout.ready  = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    rst_ni      = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // run broken by a non-magic byte, a timeout while hunting keeps the run
    send_word(OP_BYTE, MAGIC_BYTE);
    send_word(OP_BYTE, MAGIC_BYTE);
    send_word(OP_TIMEOUT, 8'h00);
    send_word(OP_BYTE, MAGIC_BYTE);
    send_word(OP_BYTE, 8'h55);
    send_word(OP_BYTE, 8'h00);
    send_word(OP_BYTE, 8'hFF);
    // odd-length good packet under the reset limit
    opening = {8'hFF, 8'h00, 8'h80};
    send_frame(EXP_SEQ_RST, 32'd3, opening, 1'b0, -1);

    for (int p = 0; p < 7; p++) begin
      case (p)
        0:       setting = 21'd1;
        1:       setting = 21'd2;
        2:       setting = 21'd7;
        3:       setting = 21'd1048576;
        4:       setting = MAX_LEN_RST;
        5:       setting = 21'($urandom_range(3, 40));
        default: setting = 21'($urandom_range(1, 1048576));
      endcase
      drain();
      write_max_length(setting);
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) random_packet();
    end

    drain();
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
